### sv/sha1_pkg.sv
// Shared types, constants and round functions for the SHA-1 engine.
`timescale 1ns / 1ps

package sha1_pkg;

	localparam int WORD_W   = 32;
	localparam int NUM_H    = 5;
	localparam int BLK_BITS = 512;
	localparam int LEN_W    = 61;
	localparam int FILL_W   = 6;
	localparam int RND_W    = 7;
	localparam int IDX_W    = 3;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [WORD_W-1:0] K_CH   = 32'h5A827999;
	localparam logic [WORD_W-1:0] K_PAR1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K_MAJ  = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K_PAR2 = 32'hCA62C1D6;

	// source of the byte shifted into the block register
	typedef enum logic [1:0] {
		SRC_MSG,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} src_t;

	// round group: picks f() and K
	typedef enum logic [1:0] {
		RG_CH,
		RG_PAR1,
		RG_MAJ,
		RG_PAR2
	} rgrp_t;

	typedef struct packed {
		logic             shift_byte;
		src_t             src;
		logic             len_inc;
		logic             len_clr;
		logic             cmp_init;
		logic             cmp_round;
		rgrp_t            grp;
		logic             cmp_add;
		logic             emit_shift;
		logic [IDX_W-1:0] word_idx;
	} cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
	} sts_t;

	function automatic logic [WORD_W-1:0] iv_word(input logic [IDX_W-1:0] idx);
		logic [WORD_W-1:0] w;
		unique case (idx)
			3'd0:    w = 32'h67452301;
			3'd1:    w = 32'hEFCDAB89;
			3'd2:    w = 32'h98BADCFE;
			3'd3:    w = 32'h10325476;
			default: w = 32'hC3D2E1F0;
		endcase
		return w;
	endfunction

	function automatic logic [WORD_W-1:0] round_k(input rgrp_t grp);
		logic [WORD_W-1:0] k;
		unique case (grp)
			RG_CH:   k = K_CH;
			RG_PAR1: k = K_PAR1;
			RG_MAJ:  k = K_MAJ;
			default: k = K_PAR2;
		endcase
		return k;
	endfunction

	function automatic logic [WORD_W-1:0] round_f(input rgrp_t grp,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
			input logic [WORD_W-1:0] d);
		logic [WORD_W-1:0] f;
		unique case (grp)
			RG_CH:   f = (b & c) | (~b & d);
			RG_MAJ:  f = (b & c) | (b & d) | (c & d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

endpackage

### sv/sha1_hash_engine.sv
// SHA-1 engine top level: byte stream in, five digest words out.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------
//  in      | in_valid, in_stall | data_byte, byte_valid, last
//  out     | out_valid,out_stall| digest_word, word_index, last_word
//
// Message bytes shift in while in_stall is low; the 64th byte of a block starts
// a compression (load, 80 rounds, chaining add) in the single shared round unit.
// On last, padding shifts one byte per cycle (64 - fill, or 128 - fill when
// the length does not fit), with no shift when the zeros reach the length slot,
// plus one or two compressions, then five digest transfers. Input is stalled
// from block completion until that compression ends, and after last until the
// last digest transfer. Reset restores the IV and clears length and fill at once.
`timescale 1ns / 1ps

module sha1_hash_engine import sha1_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              byte_valid,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] digest_word,
	output logic [IDX_W-1:0]  word_index,
	output logic              last_word
);

	cmd_t cmd;
	sts_t sts;

	sha1_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_valid (byte_valid),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.word_index (word_index),
		.last_word  (last_word),
		.sts        (sts),
		.cmd        (cmd)
	);

	sha1_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.sts         (sts),
		.digest_word (digest_word)
	);

endmodule

### sv/sha1_dp.sv
// SHA-1 datapath: block shift register, round variables, chaining value, length.
`timescale 1ns / 1ps

module sha1_dp import sha1_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [7:0]        data_byte,
	output sts_t              sts,
	output logic [WORD_W-1:0] digest_word
);

	// block word j sits at blk_q[BLK_BITS-1-WORD_W*j -: WORD_W]
	logic [BLK_BITS-1:0] blk_q;
	logic [WORD_W-1:0]   a_q, b_q, c_q, d_q, e_q;
	logic [WORD_W-1:0]   h_q [NUM_H];
	logic [LEN_W-1:0]    len_q;
	logic [FILL_W-1:0]   fill_q;

	logic [63:0]         bit_len;
	logic [7:0]          len_byte;
	logic [7:0]          in_byte;
	logic [WORD_W-1:0]   w0, w2, w8, w13, w_mix, w_new, t_sum;

	assign bit_len  = {len_q, 3'b000};
	// fill 56..63 walks the length bytes, most significant first
	assign len_byte = bit_len[63 - 8 * fill_q[2:0] -: 8];

	always_comb begin
		unique case (cmd.src)
			SRC_MSG:  in_byte = data_byte;
			SRC_PAD:  in_byte = PAD_BYTE;
			SRC_ZERO: in_byte = 8'h00;
			default:  in_byte = len_byte;
		endcase
	end

	assign w0    = blk_q[BLK_BITS-1                -: WORD_W];
	assign w2    = blk_q[BLK_BITS-1 - WORD_W * 2   -: WORD_W];
	assign w8    = blk_q[BLK_BITS-1 - WORD_W * 8   -: WORD_W];
	assign w13   = blk_q[BLK_BITS-1 - WORD_W * 13  -: WORD_W];
	assign w_mix = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

	assign t_sum = {a_q[WORD_W-6:0], a_q[WORD_W-1 -: 5]}
		+ round_f(cmd.grp, b_q, c_q, d_q) + e_q + round_k(cmd.grp) + w0;

	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			blk_q <= {blk_q[BLK_BITS-9:0], in_byte};
		end else if (cmd.cmp_round) begin
			blk_q <= {blk_q[BLK_BITS-WORD_W-1:0], w_new};
		end
		if (cmd.cmp_init) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.cmp_round) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[WORD_W-1:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_H; i++) begin
				h_q[i] <= iv_word(IDX_W'(i));
			end
			len_q  <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.cmp_add) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end else if (cmd.emit_shift) begin
				// digest leaves from h0; IV refills from the top
				for (int i = 0; i < NUM_H - 1; i++) begin
					h_q[i] <= h_q[i+1];
				end
				h_q[NUM_H-1] <= iv_word(cmd.word_idx);
			end
			if (cmd.len_clr) begin
				len_q <= '0;
			end else if (cmd.len_inc) begin
				len_q <= len_q + LEN_W'(1);
			end
			if (cmd.shift_byte) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	assign sts.fill    = fill_q;
	assign digest_word = h_q[0];

endmodule

### sv/sha1_ctrl.sv
// SHA-1 controller: byte intake, padding sequence, round count, digest transfers.
`timescale 1ns / 1ps

module sha1_ctrl import sha1_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             byte_valid,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [IDX_W-1:0] word_index,
	output logic             last_word,
	input  sts_t             sts,
	output cmd_t             cmd
);

	typedef enum logic [2:0] {
		ST_ACCEPT,
		ST_PAD80,
		ST_PADZ,
		ST_PADLEN,
		ST_CINIT,
		ST_CRND,
		ST_CADD,
		ST_EMIT
	} state_t;

	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(63);
	localparam logic [FILL_W-1:0] FILL_LEN  = FILL_W'(56);
	localparam logic [RND_W-1:0]  RND_LAST  = RND_W'(79);

	state_t            state_q, ret_q;
	logic [RND_W-1:0]  rnd_q;
	logic              out_valid_q, last_q;
	logic [IDX_W-1:0]  idx_q;
	logic              in_xfer, out_xfer, fill_end;
	rgrp_t             grp;

	assign in_stall = (state_q != ST_ACCEPT);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign fill_end = (sts.fill == FILL_FULL);

	always_comb begin
		priority if (rnd_q < RND_W'(20)) grp = RG_CH;
		else if (rnd_q < RND_W'(40))     grp = RG_PAR1;
		else if (rnd_q < RND_W'(60))     grp = RG_MAJ;
		else                             grp = RG_PAR2;
	end

	always_comb begin
		cmd            = '0;
		cmd.src        = SRC_MSG;
		cmd.grp        = grp;
		cmd.word_idx   = idx_q;
		unique case (state_q)
			ST_ACCEPT: begin
				cmd.shift_byte = in_xfer && byte_valid;
				cmd.len_inc    = in_xfer && byte_valid;
			end
			ST_PAD80: begin
				cmd.shift_byte = 1'b1;
				cmd.src        = SRC_PAD;
			end
			ST_PADZ: begin
				cmd.shift_byte = (sts.fill != FILL_LEN);
				cmd.src        = SRC_ZERO;
			end
			ST_PADLEN: begin
				cmd.shift_byte = 1'b1;
				cmd.src        = SRC_LEN;
			end
			ST_CINIT: cmd.cmp_init  = 1'b1;
			ST_CRND:  cmd.cmp_round = 1'b1;
			ST_CADD:  cmd.cmp_add   = 1'b1;
			ST_EMIT: begin
				cmd.emit_shift = out_xfer;
				cmd.len_clr    = out_xfer && last_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCEPT;
			ret_q       <= ST_ACCEPT;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			idx_q       <= '0;
		end else begin
			unique case (state_q)
				ST_ACCEPT: begin
					if (in_xfer) begin
						if (byte_valid && fill_end) begin
							state_q <= ST_CINIT;
							ret_q   <= last ? ST_PAD80 : ST_ACCEPT;
						end else if (last) begin
							state_q <= ST_PAD80;
						end
					end
				end
				ST_PAD80: begin
					if (fill_end) begin
						state_q <= ST_CINIT;
						ret_q   <= ST_PADZ;
					end else begin
						state_q <= ST_PADZ;
					end
				end
				ST_PADZ: begin
					if (sts.fill == FILL_LEN) begin
						state_q <= ST_PADLEN;
					end else if (fill_end) begin
						state_q <= ST_CINIT;
						ret_q   <= ST_PADZ;
					end
				end
				ST_PADLEN: begin
					if (fill_end) begin
						state_q <= ST_CINIT;
						ret_q   <= ST_EMIT;
					end
				end
				ST_CINIT: begin
					rnd_q   <= '0;
					state_q <= ST_CRND;
				end
				ST_CRND: begin
					rnd_q <= rnd_q + RND_W'(1);
					if (rnd_q == RND_LAST) begin
						state_q <= ST_CADD;
					end
				end
				ST_CADD: begin
					rnd_q   <= '0;
					state_q <= ret_q;
					if (ret_q == ST_EMIT) begin
						out_valid_q <= 1'b1;
						idx_q       <= '0;
						last_q      <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (out_xfer) begin
						if (last_q) begin
							out_valid_q <= 1'b0;
							last_q      <= 1'b0;
							idx_q       <= '0;
							state_q     <= ST_ACCEPT;
						end else begin
							idx_q  <= idx_q + IDX_W'(1);
							last_q <= (idx_q == IDX_W'(NUM_H - 2));
						end
					end
				end
				default: state_q <= ST_ACCEPT;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign word_index = idx_q;
	assign last_word  = last_q;

endmodule

### dv/sha1_hash_engine_tb.sv
// Self-checking testbench for the SHA-1 engine: byte stream in, digest words checked.
`timescale 1ns / 1ps

module sha1_hash_engine_tb;
	import sha1_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 600;
	localparam int TARGET_ITEMS   = 380;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [7:0] data;
		logic       bv;
		logic       fin;
	} byte_item_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic [IDX_W-1:0]  idx;
		logic              fin;
	} digest_exp_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic [7:0]        data_byte  = 8'h00;
	logic              byte_valid = 1'b0;
	logic              last       = 1'b0;
	logic              out_stall  = 1'b0;
	wire               in_stall;
	wire               out_valid;
	wire [WORD_W-1:0]  digest_word;
	wire [IDX_W-1:0]   word_index;
	wire               last_word;

	// hash state of the predictor
	logic [WORD_W-1:0] chain_h [NUM_H];
	logic [7:0]        block_buf [64];
	logic [LEN_W-1:0]  msg_len;

	byte_item_t  msg_items [$];
	digest_exp_t expected_digest [$];

	int phase        = 0;
	int items_queued = 0;
	int mismatches   = 0;
	int idle_cycles  = 0;
	int hold_left    = 0;
	bit held         = 1'b0;

	sha1_hash_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.byte_valid(byte_valid),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void load_iv();
		chain_h[0] = 32'h67452301;
		chain_h[1] = 32'hEFCDAB89;
		chain_h[2] = 32'h98BADCFE;
		chain_h[3] = 32'h10325476;
		chain_h[4] = 32'hC3D2E1F0;
	endfunction

	function automatic void sha1_compress();
		logic [WORD_W-1:0] w [16];
		logic [WORD_W-1:0] a, b, c, d, e, f, k, t, x;
		int i, r;
		for (i = 0; i < 16; i++)
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (r = 0; r < 80; r++) begin
			// schedule kept as a 16-word rolling window
			if (r >= 16) begin
				x = w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16];
				w[r%16] = {x[30:0], x[31]};
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_CH;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_PAR1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = K_PAR2;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[r%16];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endfunction

	function automatic void sha1_absorb(input logic [7:0] data, input logic bv, input logic fin);
		logic [5:0]  fill;
		logic [63:0] bit_len;
		digest_exp_t rec;
		int i;
		if (bv) begin
			block_buf[msg_len[5:0]] = data;
			msg_len = msg_len + 1'b1;
			if (msg_len[5:0] == 6'd0)
				sha1_compress();
		end
		if (fin) begin
			fill = msg_len[5:0];
			block_buf[fill] = PAD_BYTE;
			for (i = fill + 1; i < 64; i++)
				block_buf[i] = 8'h00;
			// no room for the length: flush and pad a second block
			if (fill >= 6'd56) begin
				sha1_compress();
				for (i = 0; i < 64; i++)
					block_buf[i] = 8'h00;
			end
			bit_len = {msg_len, 3'b000};
			for (i = 0; i < 8; i++)
				block_buf[63-i] = bit_len[8*i +: 8];
			sha1_compress();
			for (i = 0; i < NUM_H; i++) begin
				rec.word = chain_h[i];
				rec.idx  = i[IDX_W-1:0];
				rec.fin  = (i == NUM_H - 1);
				expected_digest.push_back(rec);
			end
			load_iv();
			msg_len = '0;
		end
	endfunction

	function automatic void queue_item(input logic [7:0] data, input logic bv, input logic fin);
		byte_item_t it;
		it.data = data;
		it.bv   = bv;
		it.fin  = fin;
		msg_items.push_back(it);
		items_queued++;
	endfunction

	function automatic void queue_message(input int len, input bit noisy);
		bit byte_on_last;
		int n;
		byte_on_last = (len > 0) && ($urandom_range(0, 1) == 1);
		for (n = 0; n < len; n++) begin
			if (noisy && $urandom_range(0, 99) < 8)
				queue_item(8'($urandom), 1'b0, 1'b0);
			queue_item(8'($urandom), 1'b1, byte_on_last && (n == len - 1));
		end
		if (!byte_on_last)
			queue_item(8'($urandom), 1'b0, 1'b1);
	endfunction

	function automatic int pick_length();
		int edges [6] = '{55, 56, 57, 63, 64, 65};
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(0, 12);
		if (r < 90)
			return edges[$urandom_range(0, 5)];
		return $urandom_range(119, 128);
	endfunction

	// driver: presents queued items, feeds accepted ones to the predictor
	always @(posedge clk or negedge arst_n) begin : driver
		byte_item_t it;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			data_byte  <= 8'h00;
			byte_valid <= 1'b0;
			last       <= 1'b0;
			load_iv();
			msg_len = '0;
		end else begin
			if (in_valid && !in_stall)
				sha1_absorb(data_byte, byte_valid, last);
			if (!in_valid || !in_stall) begin
				if (msg_items.size() != 0 &&
						$urandom_range(0, 99) >= (phase == 0 ? 23 : phase == 1 ? 72 : 0)) begin
					it = msg_items.pop_front();
					in_valid   <= 1'b1;
					data_byte  <= it.data;
					byte_valid <= it.bv;
					last       <= it.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off once the last phase starts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			held      <= 1'b0;
		end else if (phase == 2 && !held) begin
			hold_left <= HOLD_CYCLES;
			held      <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		digest_exp_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_digest.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected digest transfer: word %h index %0d last %0b",
							digest_word, word_index, last_word);
				end else begin
					want = expected_digest.pop_front();
					if (digest_word !== want.word || word_index !== want.idx ||
							last_word !== want.fin) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("digest mismatch: exp %h idx %0d last %0b, got %h idx %0d last %0b",
								want.word, want.idx, want.fin,
								digest_word, word_index, last_word);
					end
				end
			end
			out_stall <= (hold_left != 0) ||
				($urandom_range(0, 99) < (phase == 0 ? 72 : phase == 1 ? 23 : 0));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("** sha1_hash_engine: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int p, goal, len;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message, idle item, data ignored on an empty final item
		queue_item(8'h00, 1'b0, 1'b1);
		queue_item(8'hFF, 1'b0, 1'b0);
		queue_item(8'hFF, 1'b0, 1'b1);
		// single bytes and three-byte messages, closing on the byte and with an empty final item
		queue_item(8'h00, 1'b1, 1'b1);
		queue_item(8'hFF, 1'b1, 1'b0);
		queue_item(8'h5A, 1'b0, 1'b1);
		queue_item(8'hAA, 1'b1, 1'b0);
		queue_item(8'h55, 1'b1, 1'b0);
		queue_item(8'h80, 1'b1, 1'b1);
		queue_item(8'h61, 1'b1, 1'b0);
		queue_item(8'h62, 1'b1, 1'b0);
		queue_item(8'h63, 1'b1, 1'b0);
		queue_item(8'h00, 1'b0, 1'b0);
		queue_item(8'h7F, 1'b0, 1'b1);

		for (p = 0; p < 3; p++) begin
			phase <= p;
			// long message up front so the hold-off backs the engine up
			if (p == 2)
				queue_message(100, 1'b0);
			goal = TARGET_ITEMS * (p + 1) / 3;
			while (items_queued < goal) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 3))
						queue_item(8'($urandom), 1'b0, 1'b0);
				end else begin
					// keep the phase close to its share of items
					len = pick_length();
					if (len > goal - items_queued)
						len = goal - items_queued;
					queue_message(len, 1'b1);
				end
			end
			// sender pause: drain everything before the next phase
			while (msg_items.size() != 0 || in_valid || expected_digest.size() != 0)
				@(negedge clk);
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("** sha1_hash_engine: PASSED **");
		else
			$display("** sha1_hash_engine: FAILED **");
		$finish;
	end

endmodule
